[sv/itrd_pkg.sv]
// Shared constants, command and status types, and digit tables for the radix converter.
package itrd_pkg;

   localparam int VALUE_BITS  = 31;
   localparam int DIGIT_SLOTS = 32;
   localparam int SLOT_BITS   = $clog2(DIGIT_SLOTS);
   localparam int COUNT_BITS  = $clog2(DIGIT_SLOTS + 1);
   localparam int DIGIT_BITS  = 4;
   localparam int CHAR_BITS   = 7;
   localparam int RADIX_BITS  = 5;
   localparam int REM_BITS    = 6;
   localparam int RECIP_BITS  = VALUE_BITS + 1;
   localparam int PROD_BITS   = VALUE_BITS + RECIP_BITS;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 5'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 5'd10;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 7'd48;
   localparam logic [CHAR_BITS-1:0] CHAR_A    = 7'd65;

   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_BITS;

   typedef struct packed {
      logic load;
      logic mul;
      logic div;
      logic emit;
   } itrd_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic ptr_zero;
   } itrd_status_type;

   // floor(2^RECIP_BITS / radix); the quotient estimate is then at most one low.
   function automatic logic [RECIP_BITS-1:0] recip(input logic [RADIX_BITS-1:0] r);
      logic [RECIP_BITS-1:0] m;
      case (r)
         5'd2:    m = RECIP_BITS'(RECIP_ONE / 2);
         5'd3:    m = RECIP_BITS'(RECIP_ONE / 3);
         5'd4:    m = RECIP_BITS'(RECIP_ONE / 4);
         5'd5:    m = RECIP_BITS'(RECIP_ONE / 5);
         5'd6:    m = RECIP_BITS'(RECIP_ONE / 6);
         5'd7:    m = RECIP_BITS'(RECIP_ONE / 7);
         5'd8:    m = RECIP_BITS'(RECIP_ONE / 8);
         5'd9:    m = RECIP_BITS'(RECIP_ONE / 9);
         5'd10:   m = RECIP_BITS'(RECIP_ONE / 10);
         5'd11:   m = RECIP_BITS'(RECIP_ONE / 11);
         5'd12:   m = RECIP_BITS'(RECIP_ONE / 12);
         5'd13:   m = RECIP_BITS'(RECIP_ONE / 13);
         5'd14:   m = RECIP_BITS'(RECIP_ONE / 14);
         5'd15:   m = RECIP_BITS'(RECIP_ONE / 15);
         default: m = RECIP_BITS'(RECIP_ONE / 16);
      endcase
      return m;
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d <= 4'd9) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         c = CHAR_A + CHAR_BITS'(d - 4'd10);
      end
      return c;
   endfunction

endpackage

[sv/itrd_ctrl.sv]
// Sequencer for the radix converter: load, divide loop and character emission.
module itrd_ctrl
   import itrd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  itrd_status_type status,
   output itrd_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_MUL  = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = status.conv_done ? ST_EMIT : ST_MUL;
         end
         ST_EMIT: begin
            if (status.ptr_zero) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy     = (state_ff != ST_IDLE);
   assign cmd.load = (state_ff == ST_IDLE) && start;
   assign cmd.mul  = (state_ff == ST_MUL);
   assign cmd.div  = (state_ff == ST_DIV);
   assign cmd.emit = (state_ff == ST_EMIT);

   a_accept_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_MUL))
      else $error("accepted request did not start the divide loop");

   a_loop_continues: assert property (@(posedge clock) disable iff (reset)
      (cmd.div && !status.conv_done) |=> cmd.mul)
      else $error("divide loop stopped before the quotient reached zero");

   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.ptr_zero) |=> !busy)
      else $error("controller stayed busy after the last character");

endmodule

[sv/itrd_dpath.sv]
// Datapath: radix register, reciprocal divider, digit store and output register.
module itrd_dpath
   import itrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  itrd_cmd_type          cmd,
   output itrd_status_type       status,
   input  logic                  csr_we,
   input  logic [RADIX_BITS-1:0] csr_data,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_strobe,
   output logic [CHAR_BITS-1:0]  rsp_character,
   output logic                  rsp_last
);

   logic [RADIX_BITS-1:0] radix_ff;
   logic [RECIP_BITS-1:0] recip_ff;
   logic [VALUE_BITS-1:0] quot_ff;
   logic [VALUE_BITS-1:0] q_est_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [SLOT_BITS-1:0]  rd_ptr_ff;
   logic [DIGIT_BITS-1:0] rd_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_last_ff;

   logic [DIGIT_BITS-1:0] digit_store [DIGIT_SLOTS];

   logic [PROD_BITS-1:0]  prod;
   logic [REM_BITS-1:0]   qr_low;
   logic [REM_BITS-1:0]   rem_raw;
   logic                  corr;
   logic [DIGIT_BITS-1:0] digit;
   logic [VALUE_BITS-1:0] q_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
         recip_ff <= recip(RADIX_RESET);
      end else if (csr_we) begin
         if (csr_data < RADIX_MIN) begin
            radix_ff <= RADIX_MIN;
            recip_ff <= recip(RADIX_MIN);
         end else if (csr_data > RADIX_MAX) begin
            radix_ff <= RADIX_MAX;
            recip_ff <= recip(RADIX_MAX);
         end else begin
            radix_ff <= csr_data;
            recip_ff <= recip(csr_data);
         end
      end
   end

   assign prod = PROD_BITS'(quot_ff) * PROD_BITS'(recip_ff);

   // The true remainder is below twice the radix, so the low bits suffice.
   assign qr_low  = REM_BITS'(q_est_ff[REM_BITS-1:0] * REM_BITS'(radix_ff));
   assign rem_raw = quot_ff[REM_BITS-1:0] - qr_low;
   assign corr    = (rem_raw >= REM_BITS'(radix_ff));
   assign digit   = DIGIT_BITS'(corr ? (rem_raw - REM_BITS'(radix_ff)) : rem_raw);
   assign q_next  = q_est_ff + VALUE_BITS'(corr);

   assign status.conv_done = (q_next == '0) || (count_ff == COUNT_BITS'(DIGIT_SLOTS - 1));
   assign status.ptr_zero  = (rd_ptr_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         quot_ff <= req_value;
      end else if (cmd.div) begin
         quot_ff <= q_next;
      end
      if (cmd.mul) begin
         q_est_ff <= prod[RECIP_BITS +: VALUE_BITS];
      end
      if (cmd.div) begin
         rd_ptr_ff <= count_ff[SLOT_BITS-1:0];
      end else if (cmd.emit) begin
         rd_ptr_ff <= rd_ptr_ff - 1'b1;
      end
      if (cmd.emit) begin
         rsp_last_ff <= (rd_ptr_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div) begin
         digit_store[count_ff[SLOT_BITS-1:0]] <= digit;
      end
      if (cmd.emit) begin
         rd_data_ff <= digit_store[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            count_ff <= '0;
         end else if (cmd.div) begin
            count_ff <= count_ff + 1'b1;
         end
         rsp_valid_ff <= cmd.emit;
      end
   end

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_character = digit_char(rd_data_ff);
   assign rsp_last      = rsp_last_ff;

   a_strobe_follows_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(cmd.emit))
      else $error("result strobe without a digit store read");

   a_store_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> (count_ff < COUNT_BITS'(DIGIT_SLOTS)))
      else $error("digit written beyond the store");

   a_last_on_final_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.ptr_zero) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final character not flagged as last");

endmodule

[sv/integer_to_radix_digits.sv]
// Top level of the integer to radix digit string converter.
//
// A request is taken on req_value at a rising edge where start is high and
// busy is low. The value is divided by the configured radix once per digit,
// least significant digit first, using a reciprocal multiply and a one-step
// correction; each digit is a multiply step, then a correct-and-store step.
// The digits are then read back from a small store, most significant first,
// one per cycle. Each ASCII character appears on rsp_character for exactly
// one cycle with rsp_strobe high; rsp_last marks the final one. Zero gives a
// single '0'. The receiver cannot stall the output.
// The first character shows only after the last digit has been stored, and
// busy stays high until the last digit is read back, so a new request waits
// for the current one to finish.
// The radix is written through csr_valid/csr_ready/csr_data while idle;
// values below 2 store 2 and above 16 store 16.
// Synchronous reset returns the sequencer to idle, drops the strobe and sets
// the radix to 10. The digit store needs no clearing.
module integer_to_radix_digits
   import itrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_strobe,
   output logic [CHAR_BITS-1:0]  rsp_character,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [RADIX_BITS-1:0] csr_data
);

   itrd_cmd_type    cmd;
   itrd_status_type status;

   assign csr_ready = !busy;

   itrd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   itrd_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .csr_we        (csr_valid && csr_ready),
      .csr_data      (csr_data),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule
